[rtl/core/spq_pkg.sv]
package spq_pkg;

  typedef struct packed {
    logic [7:0]  dest;
    logic [7:0]  source;
    logic        prio;
    logic [7:0]  kind;
    logic [15:0] tag;
  } payload_t;

  typedef struct packed {
    payload_t    payload;
    logic [31:0] seq;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_SCAN = 2'd1,
    S_MOVE = 2'd2,
    S_DONE = 2'd3
  } state_t;

endpackage

[rtl/core/stable_priority_packet_queue.sv]
// Push, dropped push and pop on an empty queue need no scan. Pop with N stored items:
// one RAM read per stored entry through a single comparator, then the chosen slot is
// refilled with the last entry. In every case the result is registered into the output
// and the next item is taken only once it is loaded there, which waits while the output
// is stalled. Synchronous active-low reset empties the queue and clears the sequence
// counter; the entry RAM itself is not cleared.
module stable_priority_packet_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_packet_tag,
  input  logic [7:0]  in_packet_kind,
  input  logic        in_priority_req,
  input  logic [7:0]  in_source_node,
  input  logic [7:0]  in_dest_node,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic [7:0]  out_kind,
  output logic        out_priority,
  output logic [7:0]  out_source,
  output logic [7:0]  out_dest,
  output logic [4:0]  out_occupancy,
  output logic        out_queue_empty
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [31:0]       seq_r, seq_nxt;
  logic [CW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]     cmp_idx_r, cmp_idx_nxt;
  spq_pkg::entry_t   best_r, best_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  spq_pkg::entry_t   last_r, last_nxt;
  spq_pkg::status_t  pend_status_r, pend_status_nxt;
  spq_pkg::payload_t pend_payload_r, pend_payload_nxt;
  logic              out_valid_r, out_valid_nxt;
  spq_pkg::status_t  out_status_r, out_status_nxt;
  spq_pkg::payload_t out_payload_r, out_payload_nxt;
  logic [4:0]        out_occ_r, out_occ_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  spq_pkg::entry_t   ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [spq_pkg::EntryWidth-1:0] ram_rdata;
  spq_pkg::entry_t   rd_entry;
  logic              cand_wins;

  logic              in_fire;
  logic              out_free;
  logic              full;
  logic [AW-1:0]     last_idx;
  logic              scan_last;
  spq_pkg::payload_t in_payload;

  assign in_ready  = (state_r == spq_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign full      = (count_r == CW'(QUEUE_DEPTH));
  assign last_idx  = AW'(count_r - CW'(1));
  assign scan_last = cmp_vld_r && (cmp_idx_r == last_idx);
  assign rd_entry  = spq_pkg::entry_t'(ram_rdata);

  always_comb begin
    in_payload.tag    = in_packet_tag;
    in_payload.kind   = in_packet_kind;
    in_payload.prio   = in_priority_req;
    in_payload.source = in_source_node;
    in_payload.dest   = in_dest_node;
  end

  spq_ram #(
    .WIDTH(spq_pkg::EntryWidth),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  spq_rank u_rank (
    .cand    (rd_entry),
    .best    (best_r),
    .outranks(cand_wins)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == spq_pkg::CMD_POP && count_r != '0) begin
            state_nxt = spq_pkg::S_SCAN;
          end else begin
            state_nxt = spq_pkg::S_DONE;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = spq_pkg::S_MOVE;
        end
      end
      spq_pkg::S_MOVE: begin
        state_nxt = spq_pkg::S_DONE;
      end
      spq_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt        = count_r;
    seq_nxt          = seq_r;
    rd_idx_nxt       = rd_idx_r;
    cmp_vld_nxt      = 1'b0;
    cmp_idx_nxt      = cmp_idx_r;
    best_nxt         = best_r;
    best_idx_nxt     = best_idx_r;
    last_nxt         = last_r;
    pend_status_nxt  = pend_status_r;
    pend_payload_nxt = pend_payload_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_status_nxt   = out_status_r;
    out_payload_nxt  = out_payload_r;
    out_occ_nxt      = out_occ_r;
    out_empty_nxt    = out_empty_r;
    ram_we           = 1'b0;
    ram_waddr        = count_r[AW-1:0];
    ram_wdata.payload = in_payload;
    ram_wdata.seq     = seq_r;
    ram_re           = 1'b0;
    ram_raddr        = rd_idx_r[AW-1:0];
    case (state_r)
      spq_pkg::S_IDLE: begin
        rd_idx_nxt       = '0;
        pend_payload_nxt = '0;
        if (in_fire) begin
          if (in_cmd == spq_pkg::CMD_PUSH) begin
            if (full) begin
              pend_status_nxt = spq_pkg::ST_DROPPED;
            end else begin
              ram_we          = 1'b1;
              count_nxt       = count_r + CW'(1);
              seq_nxt         = seq_r + 32'd1;
              pend_status_nxt = spq_pkg::ST_PUSHED;
            end
          end else if (count_r == '0) begin
            pend_status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            pend_status_nxt = spq_pkg::ST_POPPED;
          end
        end
      end
      spq_pkg::S_SCAN: begin
        if (rd_idx_r < count_r) begin
          ram_re      = 1'b1;
          rd_idx_nxt  = rd_idx_r + CW'(1);
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r[AW-1:0];
        end
        if (cmp_vld_r) begin
          if (cmp_idx_r == '0 || cand_wins) begin
            best_nxt     = rd_entry;
            best_idx_nxt = cmp_idx_r;
          end
          if (scan_last) begin
            last_nxt = rd_entry;
          end
        end
      end
      spq_pkg::S_MOVE: begin
        ram_we           = 1'b1;
        ram_waddr        = best_idx_r;
        ram_wdata        = last_r;
        count_nxt        = count_r - CW'(1);
        pend_payload_nxt = best_r.payload;
      end
      spq_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = pend_status_r;
          out_payload_nxt = pend_payload_r;
          out_occ_nxt     = 5'(count_r);
          out_empty_nxt   = (count_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      count_r     <= '0;
      seq_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r       <= rd_idx_nxt;
    cmp_idx_r      <= cmp_idx_nxt;
    best_r         <= best_nxt;
    best_idx_r     <= best_idx_nxt;
    last_r         <= last_nxt;
    pend_status_r  <= pend_status_nxt;
    pend_payload_r <= pend_payload_nxt;
    out_status_r   <= out_status_nxt;
    out_payload_r  <= out_payload_nxt;
    out_occ_r      <= out_occ_nxt;
    out_empty_r    <= out_empty_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_tag         = out_payload_r.tag;
  assign out_kind        = out_payload_r.kind;
  assign out_priority    = out_payload_r.prio;
  assign out_source      = out_payload_r.source;
  assign out_dest        = out_payload_r.dest;
  assign out_occupancy   = out_occ_r;
  assign out_queue_empty = out_empty_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("Stored count exceeds the queue depth.");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_cmd == spq_pkg::CMD_PUSH && !full) |=>
      (count_r == $past(count_r) + CW'(1)) && (seq_r == $past(seq_r) + 32'd1))
    else $error("Accepted push did not advance count and sequence.");

  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::S_SCAN) |-> (rd_idx_r <= count_r))
    else $error("Scan read index ran past the stored count.");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != spq_pkg::ST_POPPED) |-> (out_payload_r == '0))
    else $error("Non-pop result carries packet fields.");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == spq_pkg::S_MOVE) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("Pop did not remove exactly one item.");

endmodule

[rtl/core/spq_ram.sv]
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/spq_rank.sv]
module spq_rank (
  input  spq_pkg::entry_t cand,
  input  spq_pkg::entry_t best,
  output logic            outranks
);

  logic [31:0] seq_diff;

  assign seq_diff = cand.seq - best.seq;

  always_comb begin
    if (cand.payload.prio != best.payload.prio) begin
      outranks = cand.payload.prio;
    end else begin
      outranks = seq_diff[31];
    end
  end

endmodule

[tb/sv/stable_priority_packet_queue_tb.sv]
`timescale 1ns / 1ps

module stable_priority_packet_queue_tb;

  localparam int Depth = 16;
  localparam int IdleLimit = 2000;
  localparam int RandomItems = 1950;

  typedef struct {
    spq_pkg::status_t  status;
    spq_pkg::payload_t pkt;
    logic [4:0]        occupancy;
    logic              empty;
  } queue_result_t;

  class pop_order_tracker;
    spq_pkg::payload_t slots[Depth];
    logic [31:0]       seqs[Depth];
    int unsigned       count;
    logic [31:0]       next_seq;
    queue_result_t     owed[$];
    int                errors;

    function new();
      count = 0;
      next_seq = '0;
      errors = 0;
    endfunction

    function bit outranks(int unsigned i, int unsigned j);
      logic [31:0] diff;
      if (slots[i].prio != slots[j].prio) begin
        return slots[i].prio > slots[j].prio;
      end
      diff = seqs[i] - seqs[j];
      return diff[31];
    endfunction

    function void note_item(logic cmd, spq_pkg::payload_t pkt);
      queue_result_t r;
      int unsigned best;
      r.pkt = '0;
      if (cmd == spq_pkg::CMD_PUSH) begin
        if (count >= Depth) begin
          r.status = spq_pkg::ST_DROPPED;
        end else begin
          slots[count] = pkt;
          seqs[count] = next_seq;
          next_seq = next_seq + 1;
          count++;
          r.status = spq_pkg::ST_PUSHED;
        end
      end else if (count == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        best = 0;
        for (int unsigned i = 1; i < count; i++) begin
          if (outranks(i, best)) begin
            best = i;
          end
        end
        r.pkt = slots[best];
        slots[best] = slots[count - 1];
        seqs[best] = seqs[count - 1];
        count--;
        r.status = spq_pkg::ST_POPPED;
      end
      r.occupancy = count[4:0];
      r.empty = (count == 0);
      owed.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(queue_result_t got);
      queue_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("tag", want.pkt.tag, got.pkt.tag);
      compare_field("kind", want.pkt.kind, got.pkt.kind);
      compare_field("priority", want.pkt.prio, got.pkt.prio);
      compare_field("source", want.pkt.source, got.pkt.source);
      compare_field("dest", want.pkt.dest, got.pkt.dest);
      compare_field("occupancy", want.occupancy, got.occupancy);
      compare_field("queue_empty", want.empty, got.empty);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = 1'b0;
  logic [15:0] in_packet_tag = '0;
  logic [7:0]  in_packet_kind = '0;
  logic        in_priority_req = 1'b0;
  logic [7:0]  in_source_node = '0;
  logic [7:0]  in_dest_node = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_tag;
  logic [7:0]  out_kind;
  logic        out_priority;
  logic [7:0]  out_source;
  logic [7:0]  out_dest;
  logic [4:0]  out_occupancy;
  logic        out_queue_empty;

  pop_order_tracker tracker = new();
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int sent = 0;

  stable_priority_packet_queue #(
    .QUEUE_DEPTH(Depth)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_packet_tag(in_packet_tag),
    .in_packet_kind(in_packet_kind),
    .in_priority_req(in_priority_req),
    .in_source_node(in_source_node),
    .in_dest_node(in_dest_node),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_tag(out_tag),
    .out_kind(out_kind),
    .out_priority(out_priority),
    .out_source(out_source),
    .out_dest(out_dest),
    .out_occupancy(out_occupancy),
    .out_queue_empty(out_queue_empty)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_item(logic cmd, spq_pkg::payload_t pkt);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_packet_tag <= pkt.tag;
    in_packet_kind <= pkt.kind;
    in_priority_req <= pkt.prio;
    in_source_node <= pkt.source;
    in_dest_node <= pkt.dest;
    do @(posedge clk); while (!in_ready);
    tracker.note_item(cmd, pkt);
    sent++;
  endtask

  task automatic send_packet(logic cmd, logic [15:0] tag, logic [7:0] kind, logic prio,
                             logic [7:0] source, logic [7:0] dest);
    spq_pkg::payload_t pkt;
    pkt.tag = tag;
    pkt.kind = kind;
    pkt.prio = prio;
    pkt.source = source;
    pkt.dest = dest;
    send_item(cmd, pkt);
  endtask

  initial begin : result_sink
    int gap;
    int seen;
    queue_result_t got;
    seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_gaps ? $urandom_range(0, 9) : 0;
      if (seen == 500) begin
        gap = 200;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.status = spq_pkg::status_t'(out_status);
      got.pkt.tag = out_tag;
      got.pkt.kind = out_kind;
      got.pkt.prio = out_priority;
      got.pkt.source = out_source;
      got.pkt.dest = out_dest;
      got.occupancy = out_occupancy;
      got.empty = out_queue_empty;
      tracker.check_result(got);
      seen++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int seg_len;
    int push_pct;
    bit paused;
    logic cmd;
    spq_pkg::payload_t pkt;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_packet(spq_pkg::CMD_POP, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    send_packet(spq_pkg::CMD_PUSH, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    send_packet(spq_pkg::CMD_PUSH, 16'hffff, 8'hff, 1'b1, 8'hff, 8'hff);
    send_packet(spq_pkg::CMD_POP, 16'hffff, 8'hff, 1'b1, 8'hff, 8'hff);
    send_packet(spq_pkg::CMD_POP, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);
    for (int i = 0; i < Depth; i++) begin
      send_packet(spq_pkg::CMD_PUSH, 16'(i * 16'h1111), 8'(i), i[1], 8'(255 - i),
                  8'(i * 7));
    end
    send_packet(spq_pkg::CMD_PUSH, 16'hbeef, 8'h5a, 1'b1, 8'ha5, 8'h3c);
    repeat (3) send_packet(spq_pkg::CMD_POP, 16'h0000, 8'h00, 1'b0, 8'h00, 8'h00);

    while (sent < RandomItems) begin
      seg_len = $urandom_range(20, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 20;
      endcase
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      if (!paused && sent >= RandomItems / 2) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        while (tracker.owed.size() != 0) @(posedge clk);
      end
      for (int k = 0; k < seg_len; k++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? spq_pkg::CMD_PUSH : spq_pkg::CMD_POP;
        pkt.tag = 16'($urandom());
        pkt.kind = 8'($urandom());
        pkt.prio = 1'($urandom());
        pkt.source = 8'($urandom());
        pkt.dest = 8'($urandom());
        send_item(cmd, pkt);
      end
    end
    in_valid <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
